[rtl/tmf_pkg.sv]
package tmf_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int MEAN_W    = 14;
    localparam int CFG_W     = 4;
    localparam int FRAC_BITS = 4;

    localparam logic [MEAN_W-1:0] MEAN_MAX           = 14'd16383;
    localparam logic [CFG_W-1:0]  REPORT_TICKS_RESET = 4'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_HOLD
    } t_tmf_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write_sample;
        logic load_copy;
        logic sort_step;
        logic sort_odd;
        logic sum_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Trim per end, reduced so that at least one value is kept
    function automatic int trim_eff(int w, int t);
        return (2 * t >= w) ? (w - 1) / 2 : t;
    endfunction

    function automatic int kept_count(int w, int t);
        return w - 2 * trim_eff(w, t);
    endfunction

    function automatic int sum_bits(int w, int t, int sb);
        return sb + $clog2(kept_count(w, t) + 1);
    endfunction

    function automatic int div_bits(int w, int t, int sb);
        return sum_bits(w, t, sb) + FRAC_BITS;
    endfunction

endpackage

[rtl/tmf_ifs.sv]
interface tmf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tmf_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, mode, sample, input ready);
    modport sink   (input valid, mode, sample, output ready);
endinterface

interface tmf_out_if;
    logic                          valid;
    logic                          ready;
    logic [tmf_pkg::MEAN_W-1:0]    trimmed_mean;

    modport source (output valid, trimmed_mean, input ready);
    modport sink   (input valid, trimmed_mean, output ready);
endinterface

interface tmf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tmf_pkg::CFG_W-1:0]     report_ticks;

    modport source (output valid, report_ticks, input ready);
    modport sink   (input valid, report_ticks, output ready);
endinterface

[rtl/trimmed_mean_sample_filter_unit.sv]
// Trimmed-mean filter for range-sensor samples.
// Input channel i_in: each request carries mode and sample. A sample request
// (mode 0) overwrites the oldest of WINDOW ring entries.
// A tick request (mode 1) counts towards report_ticks; on every report_ticks-th
// tick the block sorts a copy of the ring, drops the TRIM smallest and largest
// values and returns floor(sum * 16 / kept) of the rest on o_out, saturated to
// 14 bits. Other ticks return nothing.
// A reporting tick sorts with one transposition pass per cycle, then sums one
// kept value per cycle, then loads the dividend, multiplies it by the
// reciprocal of kept and loads the result once the output register is free;
// i_in.ready stays low over that span. The next request is taken in the cycle
// after the result loads.
// Configuration channel i_cfg writes report_ticks (reset 2) and is always
// ready; write it only while the block is idle.
// Reset (synchronous, active low) clears the ring to zeros, the write slot,
// the tick count and the output register valid.
// When the receiver stalls, the result holds in the output register; sample
// and tick requests are still taken, but a further report waits until the
// held result has been taken.
module trimmed_mean_sample_filter_unit #(
    parameter int WINDOW      = 10,
    parameter int TRIM        = 2,
    parameter int SAMPLE_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmf_in_if.sink    i_in,
    tmf_cfg_if.sink   i_cfg,
    tmf_out_if.source o_out
);
    import tmf_pkg::*;

    t_dp_cmd w_cmd;

    // Sequence the work of each request
    tmf_controller #(
        .WINDOW      (WINDOW),
        .TRIM        (TRIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.report_ticks),
        .o_cfg_ready (i_cfg.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Hold the ring, sort buffer, accumulator, divider and result register
    tmf_datapath #(
        .WINDOW      (WINDOW),
        .TRIM        (TRIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (i_in.sample),
        .o_mean   (o_out.trimmed_mean)
    );

endmodule

[rtl/tmf_datapath.sv]
module tmf_datapath #(
    parameter int WINDOW      = 10,
    parameter int TRIM        = 2,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tmf_pkg::t_dp_cmd             i_cmd,
    input  logic [tmf_pkg::SAMPLE_W-1:0] i_sample,
    output logic [tmf_pkg::MEAN_W-1:0]   o_mean
);
    import tmf_pkg::*;

    localparam int T_EFF = trim_eff(WINDOW, TRIM);
    localparam int KEPT  = kept_count(WINDOW, TRIM);
    localparam int SUMW  = sum_bits(WINDOW, TRIM, SAMPLE_BITS);
    localparam int DW    = div_bits(WINDOW, TRIM, SAMPLE_BITS);
    localparam int SW    = $clog2(WINDOW);
    // Reciprocal of the kept count, scaled so the floor is exact for any dividend
    localparam int RS    = DW + $clog2(KEPT);
    localparam int RW    = DW + 2;
    localparam int PW    = DW + RW;
    localparam int QW    = PW - RS;
    localparam longint unsigned RECIP = ((64'd1 << RS) + 64'(KEPT) - 64'd1) / 64'(KEPT);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [SW-1:0]          r_slot;
    logic [SAMPLE_BITS-1:0] r_buf  [WINDOW];
    logic [SAMPLE_BITS-1:0] n_buf  [WINDOW];
    logic [SUMW-1:0]        r_acc;
    logic [DW-1:0]          r_dividend;
    logic [QW-1:0]          r_quo;
    logic [MEAN_W-1:0]      r_mean;

    logic [SAMPLE_BITS-1:0] w_sample;
    logic [RW-1:0]          w_recip;
    logic [PW-1:0]          w_prod;
    logic [MEAN_W-1:0]      w_mean;

    assign w_sample = SAMPLE_BITS'(i_sample);

    // Ring of recent samples, oldest entry overwritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_slot <= '0;
        end else if (i_cmd.write_sample) begin
            r_ring[r_slot] <= w_sample;
            if (r_slot == SW'(WINDOW - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + SW'(1);
            end
        end
    end

    // Odd-even transposition passes, then shift down while summing
    always_comb begin
        n_buf = r_buf;
        priority if (i_cmd.load_copy) begin
            n_buf = r_ring;
        end else if (i_cmd.sort_step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                if ((i[0] == i_cmd.sort_odd) && (r_buf[i] > r_buf[i+1])) begin
                    n_buf[i]   = r_buf[i+1];
                    n_buf[i+1] = r_buf[i];
                end
            end
        end else if (i_cmd.sum_step) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
        end else begin
            n_buf = r_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (i_cmd.load_copy) begin
            r_acc <= '0;
        end else if (i_cmd.sum_step) begin
            r_acc <= r_acc + SUMW'(r_buf[T_EFF]);
        end
    end

    // Divide by the kept count: multiply by the scaled reciprocal and shift
    assign w_recip = RW'(RECIP);
    assign w_prod  = PW'(r_dividend) * PW'(w_recip);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dividend <= {r_acc, FRAC_BITS'(0)};
        end
        if (i_cmd.div_step) begin
            r_quo <= w_prod[PW-1:RS];
        end
    end

    assign w_mean = (r_quo > QW'(MEAN_MAX)) ? MEAN_MAX : r_quo[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= w_mean;
        end
    end

    assign o_mean = r_mean;

endmodule

[rtl/tmf_controller.sv]
module tmf_controller #(
    parameter int WINDOW      = 10,
    parameter int TRIM        = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_mode,
    output logic                      o_in_ready,
    input  logic                      i_cfg_valid,
    input  logic [tmf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output tmf_pkg::t_dp_cmd          o_cmd
);
    import tmf_pkg::*;

    localparam int KEPT    = kept_count(WINDOW, TRIM);
    localparam int CW      = $clog2(WINDOW);

    t_tmf_state       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CFG_W-1:0] r_tick, n_tick;
    logic [CFG_W-1:0] r_report_ticks;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic [CFG_W-1:0] w_tick_inc;
    logic             w_report_due;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_tick_inc   = r_tick + CFG_W'(1);
    assign w_report_due = (w_tick_inc >= r_report_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_tick         <= '0;
            r_report_ticks <= REPORT_TICKS_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_report_ticks <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_mode == MODE_SAMPLE) begin
                        o_cmd.write_sample = 1'b1;
                    end else if (w_report_due) begin
                        n_tick          = '0;
                        o_cmd.load_copy = 1'b1;
                        n_cnt           = '0;
                        n_state         = ST_SORT;
                    end else begin
                        n_tick = w_tick_inc;
                    end
                end
            end
            ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.sort_odd  = r_cnt[0];
                n_cnt           = r_cnt + CW'(1);
                if (r_cnt == CW'(WINDOW - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(KEPT - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = ST_HOLD;
            end
            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.write_sample, o_cmd.load_copy, o_cmd.sort_step, o_cmd.sum_step,
                  o_cmd.div_load, o_cmd.div_step, o_cmd.out_load}))
        else $error("datapath commands overlap");

    a_valid_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_HOLD))
        else $error("result raised outside the hand-over state");

    a_due_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_mode == MODE_TICK) && w_report_due) |=> (r_state == ST_SORT))
        else $error("reporting tick did not start the sort");

    a_sample_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_mode == MODE_SAMPLE)) |=> (r_state == ST_IDLE))
        else $error("sample request left the idle state");

    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (r_state == ST_HOLD))
        else $error("division took more than one cycle");
`endif

endmodule

[sim/trimmed_mean_sample_filter_unit_test.sv]
module trimmed_mean_sample_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmf_pkg::*;

    // Run limits, in clock cycles
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 400;

    // Tracks the ring, tick count and report interval on the side, and keeps
    // the trimmed means still owed by the block, oldest first.
    class trimmed_mean_scoreboard;
        localparam int WINDOW = 10;
        localparam int TRIM   = 2;
        localparam int KEPT   = WINDOW - 2 * TRIM;

        logic [SAMPLE_W-1:0] ring [WINDOW];
        int unsigned         slot;
        logic [3:0]          ticks_seen;
        logic [CFG_W-1:0]    report_ticks;
        logic [MEAN_W-1:0]   expected_means [$];
        int                  errors;
        int                  means_checked;

        function new();
            foreach (ring[i]) ring[i] = '0;
            slot          = 0;
            ticks_seen    = '0;
            report_ticks  = REPORT_TICKS_RESET;
            errors        = 0;
            means_checked = 0;
        endfunction

        function void set_report_ticks(logic [CFG_W-1:0] value);
            report_ticks = value;
        endfunction

        // Sort a copy of the ring, drop TRIM from each end, average the rest scaled by 16
        function logic [MEAN_W-1:0] middle_mean();
            logic [SAMPLE_W-1:0] sorted [WINDOW];
            logic [SAMPLE_W-1:0] swap;
            int unsigned         total;
            int unsigned         mean;
            sorted = ring;
            for (int i = 0; i < WINDOW - 1; i++) begin
                for (int j = 0; j < WINDOW - 1 - i; j++) begin
                    if (sorted[j] > sorted[j+1]) begin
                        swap        = sorted[j];
                        sorted[j]   = sorted[j+1];
                        sorted[j+1] = swap;
                    end
                end
            end
            total = 0;
            for (int i = TRIM; i < TRIM + KEPT; i++) total += sorted[i];
            mean = (total * 16) / KEPT;
            if (mean > MEAN_MAX) mean = MEAN_MAX;
            return mean[MEAN_W-1:0];
        endfunction

        function void note_request(logic mode, logic [SAMPLE_W-1:0] sample);
            if (mode == MODE_SAMPLE) begin
                ring[slot] = sample;
                slot       = (slot + 1) % WINDOW;
            end else begin
                ticks_seen = ticks_seen + 4'd1;
                if (ticks_seen >= report_ticks) begin
                    ticks_seen = '0;
                    expected_means.push_back(middle_mean());
                end
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_mean(logic [MEAN_W-1:0] got);
            logic [MEAN_W-1:0] want;
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("unexpected trimmed_mean %0d", got));
            end else begin
                want = expected_means.pop_front();
                means_checked++;
                if (got !== want)
                    report_mismatch($sformatf("trimmed_mean %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tmf_in_if  in_ch ();
    tmf_out_if out_ch ();
    tmf_cfg_if cfg_ch ();

    trimmed_mean_sample_filter_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    trimmed_mean_scoreboard board;

    int cycle_count = 0;
    int samples_sent = 0;
    int ticks_sent = 0;
    int settings_written = 0;
    int idle_odds;          // sender idles on one request in idle_odds; 0 = never
    bit quiet = 1'b0;       // no idling on either side
    bit long_hold_req = 1'b0;
    logic [SAMPLE_W-1:0] cluster_base;

    // 20 ns clock, low first so the first rising edge falls at 10 ns
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: give up well beyond the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check each trimmed mean as the handshake completes. Values sampled here
    // are those from before the edge, so the order of processes does not matter.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_mean(out_ch.trimmed_mean);
    end

    // Result receiver: random stalls in bursts, the odd long hold-off on
    // request from the stimulus, and a steady ready once the run goes quiet.
    // Each pass assigns ready once and then waits at least one edge.
    initial begin
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until taken. Valid is left high so that
    // back-to-back requests need no second assignment in the same step.
    task automatic offer_request(input logic mode, input logic [SAMPLE_W-1:0] sample);
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.sample <= sample;
        do @(posedge clk); while (!in_ch.ready);
        board.note_request(mode, sample);
        if (mode == MODE_SAMPLE) samples_sent++;
        else ticks_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold the sender until every owed trimmed mean has come back
    task automatic drain_means();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.expected_means.size() != 0);
    endtask

    // Write report_ticks only with the block idle: drain, then let any
    // unfinished report run out before touching the register
    task automatic write_report_ticks(input logic [CFG_W-1:0] value);
        drain_means();
        repeat (SETTLE) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.report_ticks <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_report_ticks(value);
        settings_written++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic tick();
        offer_request(MODE_TICK, SAMPLE_W'($urandom));
    endtask

    // Random traffic: about a third ticks; samples mix full range, the two
    // extremes and a tight cluster that makes ties in the sort likely.
    task automatic random_traffic(input int count);
        logic [SAMPLE_W-1:0] sample;
        for (int k = 0; k < count; k++) begin
            if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                pause_sender($urandom_range(1, 18));
            if ($urandom_range(0, 99) < 32) begin
                tick();
            end else begin
                case ($urandom_range(0, 5))
                    0:       sample = '0;
                    1:       sample = '1;
                    2, 3:    sample = cluster_base ^ SAMPLE_W'($urandom_range(0, 7));
                    default: sample = SAMPLE_W'($urandom_range(0, 1023));
                endcase
                offer_request(MODE_SAMPLE, sample);
            end
        end
    endtask

    task automatic traffic_phase(input logic [CFG_W-1:0] setting, input int count,
                                 input int odds);
        write_report_ticks(setting);
        idle_odds    = odds;
        cluster_base = SAMPLE_W'($urandom);
        random_traffic(count);
    endtask

    initial begin
        board = new();

        // Drive every input to a known level from the start
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_SAMPLE;
        in_ch.sample        <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.report_ticks <= REPORT_TICKS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset interval of two ticks, report of the cleared ring
        tick();
        tick();
        // Full-scale ring gives the largest mean
        repeat (10) offer_request(MODE_SAMPLE, '1);
        tick();
        tick();
        // Half zeros, half full scale: trimming cuts across the two groups
        repeat (5) offer_request(MODE_SAMPLE, '0);
        tick();
        tick();
        // Alternating bit patterns
        offer_request(MODE_SAMPLE, 10'h2AA);
        offer_request(MODE_SAMPLE, 10'h155);
        tick();
        tick();

        // Report on every tick, with a long result stall at the start so
        // the output register fills and the input backs up
        write_report_ticks(4'd1);
        long_hold_req = 1'b1;
        idle_odds     = 0;
        cluster_base  = SAMPLE_W'($urandom);
        random_traffic(220);

        // Largest and out-of-range intervals, then a spread of others
        traffic_phase(4'd15, 260, 4);
        traffic_phase(4'd0, 200, 3);
        traffic_phase(4'd7, 220, 6);
        traffic_phase(CFG_W'($urandom_range(1, 15)), 200, 2);
        traffic_phase(4'd3, 200, 0);

        // Closing stretch with no idling on either side
        quiet = 1'b1;
        traffic_phase(REPORT_TICKS_RESET, 130, 0);

        drain_means();
        repeat (SETTLE) @(posedge clk);
        if (board.expected_means.size() != 0)
            board.report_mismatch($sformatf("%0d trimmed means never arrived",
                                            board.expected_means.size()));

        $display("Sent %0d samples and %0d ticks; checked %0d trimmed means",
                 samples_sent, ticks_sent, board.means_checked);
        $display("Wrote report_ticks %0d times (0, 1 and 15 among them), %0d mismatches",
                 settings_written, board.errors);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
